FILE: rtl/gpcc_pkg.sv
// Shared constants and types of the gated preamble cross-correlator.
package gpcc_pkg;

  localparam int WINDOW_LEN_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int FIELD_W = 16;
  localparam int IDX_W   = 6;
  localparam int THR_W   = 16;
  localparam int WIN_W   = 12;
  localparam int CNT_W   = 13;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0]     COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [THR_W-1:0]     THR_RST   = 16'd32113;
  localparam logic [WIN_W-1:0]     WIN_RST   = 12'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN = 1'b1;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_DRAIN,
    ST_START,
    ST_CMP
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_AA,
    PH_BB,
    PH_EE,
    PH_TT
  } cmp_phase_t;

  typedef struct packed {
    logic clr;
    logic en;
  } corr_ctl_t;

  typedef struct packed {
    logic done;
    logic peak;
  } cmp_res_t;

endpackage

FILE: rtl/gpcc_cell.sv
// One cell of the chain: a received sample and a preamble coefficient.
module gpcc_cell #(
  parameter int SAMPLE_BITS = gpcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic                          rot_en,
  input  logic                          wr_en,
  input  logic signed [SAMPLE_BITS-1:0] wr_re,
  input  logic signed [SAMPLE_BITS-1:0] wr_im,
  input  logic signed [SAMPLE_BITS-1:0] nb_s_re,
  input  logic signed [SAMPLE_BITS-1:0] nb_s_im,
  input  logic signed [SAMPLE_BITS-1:0] nb_k_re,
  input  logic signed [SAMPLE_BITS-1:0] nb_k_im,
  output logic signed [SAMPLE_BITS-1:0] s_re,
  output logic signed [SAMPLE_BITS-1:0] s_im,
  output logic signed [SAMPLE_BITS-1:0] k_re,
  output logic signed [SAMPLE_BITS-1:0] k_im
);

  logic signed [SAMPLE_BITS-1:0] s_re_r, s_im_r, k_re_r, k_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_re_r <= '0;
      s_im_r <= '0;
      k_re_r <= '0;
      k_im_r <= '0;
    end else begin
      if (shift_en || rot_en) begin
        s_re_r <= nb_s_re;
        s_im_r <= nb_s_im;
      end
      // coefficients travel only while the chain rotates
      if (rot_en) begin
        k_re_r <= nb_k_re;
        k_im_r <= nb_k_im;
      end else if (wr_en) begin
        k_re_r <= wr_re;
        k_im_r <= wr_im;
      end
    end
  end

  assign s_re = s_re_r;
  assign s_im = s_im_r;
  assign k_re = k_re_r;
  assign k_im = k_im_r;

endmodule

FILE: rtl/gpcc_corr.sv
// Multiply-accumulate unit at the head of the chain: C, Ek and Ew.
module gpcc_corr #(
  parameter int SAMPLE_BITS = gpcc_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_W       = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gpcc_pkg::corr_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] k_re,
  input  logic signed [SAMPLE_BITS-1:0] k_im,
  input  logic signed [SAMPLE_BITS-1:0] s_re,
  input  logic signed [SAMPLE_BITS-1:0] s_im,
  output logic signed [ACC_W-1:0]       cre,
  output logic signed [ACC_W-1:0]       cim,
  output logic        [ACC_W-1:0]       ek,
  output logic        [ACC_W-1:0]       ew
);

  localparam int PW = 2 * SAMPLE_BITS;

  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [PW-1:0] p_kr_r, p_ki_r, p_sr_r, p_si_r;
  logic                 v1_r;

  logic signed [PW:0]   t_re, t_im, t_ek, t_ew;
  logic signed [ACC_W-1:0] cre_r, cim_r;
  logic        [ACC_W-1:0] ek_r, ew_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ctl.clr) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p_rr_r <= k_re * s_re;
      p_ii_r <= k_im * s_im;
      p_ri_r <= k_re * s_im;
      p_ir_r <= k_im * s_re;
      p_kr_r <= k_re * k_re;
      p_ki_r <= k_im * k_im;
      p_sr_r <= s_re * s_re;
      p_si_r <= s_im * s_im;
    end
  end

  assign t_re = (PW+1)'(p_rr_r) + (PW+1)'(p_ii_r);
  assign t_im = (PW+1)'(p_ri_r) - (PW+1)'(p_ir_r);
  assign t_ek = (PW+1)'(p_kr_r) + (PW+1)'(p_ki_r);
  assign t_ew = (PW+1)'(p_sr_r) + (PW+1)'(p_si_r);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      cre_r <= '0;
      cim_r <= '0;
      ek_r  <= '0;
      ew_r  <= '0;
    end else if (v1_r) begin
      cre_r <= cre_r + ACC_W'(t_re);
      cim_r <= cim_r + ACC_W'(t_im);
      ek_r  <= ek_r + ACC_W'($unsigned(t_ek));
      ew_r  <= ew_r + ACC_W'($unsigned(t_ew));
    end
  end

  assign cre = cre_r;
  assign cim = cim_r;
  assign ek  = ek_r;
  assign ew  = ew_r;

endmodule

FILE: rtl/gpcc_cmp.sv
// Bit-serial threshold test: |C|^2 * 2^16 > threshold_sq * Ek * Ew.
module gpcc_cmp #(
  parameter int ACC_W = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [ACC_W-1:0]        cre,
  input  logic signed [ACC_W-1:0]        cim,
  input  logic        [ACC_W-1:0]        ek,
  input  logic        [ACC_W-1:0]        ew,
  input  logic [gpcc_pkg::THR_W-1:0]     thr,
  output gpcc_pkg::cmp_res_t             res
);

  localparam int PROD_W = 2 * ACC_W + gpcc_pkg::THR_W + 1;
  localparam int BCW    = $clog2(ACC_W);

  gpcc_pkg::cmp_phase_t phase_r, phase_nxt;
  logic [BCW-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [ACC_W-1:0]  mplier_r, mplier_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] lhs_r, lhs_nxt;
  logic [ACC_W-1:0]  b_r, b_nxt;

  logic [ACC_W-1:0]  mag_a, mag_b;
  logic [PROD_W-1:0] acc_sum;
  logic              last;

  assign mag_a   = cre[ACC_W-1] ? ACC_W'(-cre) : ACC_W'(cre);
  assign mag_b   = cim[ACC_W-1] ? ACC_W'(-cim) : ACC_W'(cim);
  assign acc_sum = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign last    = (bit_cnt_r == BCW'(ACC_W - 1));

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    acc_nxt     = acc_r;
    lhs_nxt     = lhs_r;
    b_nxt       = b_r;
    res         = '0;
    case (phase_r)
      gpcc_pkg::PH_IDLE: begin
        if (start) begin
          phase_nxt   = gpcc_pkg::PH_AA;
          bit_cnt_nxt = '0;
          mcand_nxt   = PROD_W'(mag_a);
          mplier_nxt  = mag_a;
          acc_nxt     = '0;
          b_nxt       = mag_b;
        end
      end
      gpcc_pkg::PH_AA, gpcc_pkg::PH_BB, gpcc_pkg::PH_EE, gpcc_pkg::PH_TT: begin
        acc_nxt     = acc_sum;
        mcand_nxt   = mcand_r << 1;
        mplier_nxt  = mplier_r >> 1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (last) begin
          bit_cnt_nxt = '0;
          case (phase_r)
            gpcc_pkg::PH_AA: begin
              // keep |re|^2, add |im|^2 on top
              phase_nxt  = gpcc_pkg::PH_BB;
              mcand_nxt  = PROD_W'(b_r);
              mplier_nxt = b_r;
            end
            gpcc_pkg::PH_BB: begin
              phase_nxt  = gpcc_pkg::PH_EE;
              lhs_nxt    = acc_sum << gpcc_pkg::THR_W;
              acc_nxt    = '0;
              mcand_nxt  = PROD_W'(ek);
              mplier_nxt = ew;
            end
            gpcc_pkg::PH_EE: begin
              phase_nxt  = gpcc_pkg::PH_TT;
              acc_nxt    = '0;
              mcand_nxt  = acc_sum;
              mplier_nxt = ACC_W'(thr);
            end
            default: begin
              phase_nxt = gpcc_pkg::PH_IDLE;
              res.done  = 1'b1;
              res.peak  = (lhs_r > acc_sum);
            end
          endcase
        end
      end
      default: begin
        phase_nxt = gpcc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= gpcc_pkg::PH_IDLE;
      bit_cnt_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    lhs_r    <= lhs_nxt;
    b_r      <= b_nxt;
  end

endmodule

FILE: rtl/gated_preamble_cross_correlator.sv
// Gated preamble cross-correlator: chain of sample/coefficient cells and serial test.
// A preamble load (mode 0) or a received sample outside an open search gives its
// result in the cycle after it is taken. A received sample inside an open search
// rotates the cell chain once through the multiply-accumulate unit at its head,
// then runs four bit-serial products of ACC_W bits each in the threshold unit
// (ACC_W is 40 at the default WINDOW_LEN 64 and SAMPLE_BITS 16). A new beat is
// taken only once the last one is done.
module gated_preamble_cross_correlator #(
  parameter int WINDOW_LEN  = gpcc_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = gpcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic                               in_auto_peak,
  input  logic signed [gpcc_pkg::FIELD_W-1:0] in_sample_re,
  input  logic signed [gpcc_pkg::FIELD_W-1:0] in_sample_im,
  input  logic [gpcc_pkg::IDX_W-1:0]         in_coef_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_cross_peak,
  input  logic                               cfg_we,
  input  logic [gpcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpcc_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int ACC_W = 2 * SAMPLE_BITS + 2 + $clog2(WINDOW_LEN);
  localparam int ROT_W = $clog2(WINDOW_LEN);
  localparam int FW    = gpcc_pkg::FIELD_W;

  gpcc_pkg::state_t state_r, state_nxt;
  logic [ROT_W-1:0]           rot_cnt_r, rot_cnt_nxt;
  logic [gpcc_pkg::CNT_W-1:0] count_r, count_nxt, cnt_eff;
  logic                       searching_r, searching_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_peak_r, out_peak_nxt;
  logic [gpcc_pkg::THR_W-1:0] thr_r;
  logic [gpcc_pkg::WIN_W-1:0] win_r;

  logic in_acc, srch, shift_en, rot_en, coef_we, cmp_start;
  gpcc_pkg::corr_ctl_t corr_ctl;
  gpcc_pkg::cmp_res_t  cmp_res;

  logic signed [SAMPLE_BITS-1:0] new_re, new_im;
  logic signed [SAMPLE_BITS-1:0] c_s_re [WINDOW_LEN];
  logic signed [SAMPLE_BITS-1:0] c_s_im [WINDOW_LEN];
  logic signed [SAMPLE_BITS-1:0] c_k_re [WINDOW_LEN];
  logic signed [SAMPLE_BITS-1:0] c_k_im [WINDOW_LEN];

  logic signed [ACC_W-1:0] cre, cim;
  logic        [ACC_W-1:0] ek, ew;

  generate
    if (SAMPLE_BITS <= FW) begin : g_narrow
      assign new_re = in_sample_re[SAMPLE_BITS-1:0];
      assign new_im = in_sample_im[SAMPLE_BITS-1:0];
    end else begin : g_wide
      assign new_re = {{(SAMPLE_BITS-FW){1'b0}}, in_sample_re};
      assign new_im = {{(SAMPLE_BITS-FW){1'b0}}, in_sample_im};
    end
  endgenerate

  // cell 0 holds the oldest sample; new samples enter at the far end
  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] nb_s_re, nb_s_im, nb_k_re, nb_k_im;
      logic                          wr_en;
      if (gi == WINDOW_LEN - 1) begin : g_end
        assign nb_s_re = rot_en ? c_s_re[0] : new_re;
        assign nb_s_im = rot_en ? c_s_im[0] : new_im;
        assign nb_k_re = c_k_re[0];
        assign nb_k_im = c_k_im[0];
      end else begin : g_mid
        assign nb_s_re = c_s_re[gi+1];
        assign nb_s_im = c_s_im[gi+1];
        assign nb_k_re = c_k_re[gi+1];
        assign nb_k_im = c_k_im[gi+1];
      end
      assign wr_en = coef_we && (int'(in_coef_index) == gi);
      gpcc_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .rot_en   (rot_en),
        .wr_en    (wr_en),
        .wr_re    (new_re),
        .wr_im    (new_im),
        .nb_s_re  (nb_s_re),
        .nb_s_im  (nb_s_im),
        .nb_k_re  (nb_k_re),
        .nb_k_im  (nb_k_im),
        .s_re     (c_s_re[gi]),
        .s_im     (c_s_im[gi]),
        .k_re     (c_k_re[gi]),
        .k_im     (c_k_im[gi])
      );
    end
  endgenerate

  gpcc_corr #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_W      (ACC_W)
  ) u_corr (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (corr_ctl),
    .k_re  (c_k_re[0]),
    .k_im  (c_k_im[0]),
    .s_re  (c_s_re[0]),
    .s_im  (c_s_im[0]),
    .cre   (cre),
    .cim   (cim),
    .ek    (ek),
    .ew    (ew)
  );

  gpcc_cmp #(
    .ACC_W(ACC_W)
  ) u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmp_start),
    .cre   (cre),
    .cim   (cim),
    .ek    (ek),
    .ew    (ew),
    .thr   (thr_r),
    .res   (cmp_res)
  );

  assign in_ready = (state_r == gpcc_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign srch     = searching_r || in_auto_peak;
  assign cnt_eff  = in_auto_peak ? '0 : count_r;

  always_comb begin
    state_nxt     = state_r;
    rot_cnt_nxt   = rot_cnt_r;
    count_nxt     = count_r;
    searching_nxt = searching_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_peak_nxt  = out_peak_r;
    shift_en      = 1'b0;
    rot_en        = 1'b0;
    coef_we       = 1'b0;
    cmp_start     = 1'b0;
    corr_ctl      = '0;
    case (state_r)
      gpcc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == gpcc_pkg::MODE_SAMPLE) begin
            shift_en  = 1'b1;
            count_nxt = (cnt_eff == gpcc_pkg::COUNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
            if (srch) begin
              searching_nxt = (cnt_eff != {1'b0, win_r});
              corr_ctl.clr  = 1'b1;
              rot_cnt_nxt   = '0;
              state_nxt     = gpcc_pkg::ST_ROT;
            end else begin
              out_valid_nxt = 1'b1;
              out_peak_nxt  = 1'b0;
            end
          end else begin
            coef_we       = 1'b1;
            out_valid_nxt = 1'b1;
            out_peak_nxt  = 1'b0;
          end
        end
      end
      gpcc_pkg::ST_ROT: begin
        rot_en      = 1'b1;
        corr_ctl.en = 1'b1;
        rot_cnt_nxt = rot_cnt_r + 1'b1;
        if (rot_cnt_r == ROT_W'(WINDOW_LEN - 1)) begin
          state_nxt = gpcc_pkg::ST_DRAIN;
        end
      end
      gpcc_pkg::ST_DRAIN: begin
        // last product pair lands in the accumulators
        state_nxt = gpcc_pkg::ST_START;
      end
      gpcc_pkg::ST_START: begin
        cmp_start = 1'b1;
        state_nxt = gpcc_pkg::ST_CMP;
      end
      gpcc_pkg::ST_CMP: begin
        if (cmp_res.done) begin
          out_valid_nxt = 1'b1;
          out_peak_nxt  = cmp_res.peak;
          if (cmp_res.peak) begin
            searching_nxt = 1'b0;
          end
          state_nxt = gpcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gpcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpcc_pkg::ST_IDLE;
      rot_cnt_r   <= '0;
      count_r     <= '0;
      searching_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_peak_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_cnt_r   <= rot_cnt_nxt;
      count_r     <= count_nxt;
      searching_r <= searching_nxt;
      out_valid_r <= out_valid_nxt;
      out_peak_r  <= out_peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= gpcc_pkg::THR_RST;
      win_r <= gpcc_pkg::WIN_RST;
    end else if (cfg_we) begin
      if (cfg_index == gpcc_pkg::CFG_THR) begin
        thr_r <= cfg_wdata[gpcc_pkg::THR_W-1:0];
      end
      if (cfg_index == gpcc_pkg::CFG_WIN) begin
        win_r <= cfg_wdata[gpcc_pkg::WIN_W-1:0];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cross_peak = out_peak_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == gpcc_pkg::ST_IDLE)
    else $error("input ready outside idle");

  a_done_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_res.done |-> state_r == gpcc_pkg::ST_CMP)
    else $error("threshold result outside compare state");

  a_rot_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gpcc_pkg::ST_ROT && rot_cnt_r != ROT_W'(WINDOW_LEN - 1))
      |=> state_r == gpcc_pkg::ST_ROT)
    else $error("chain rotation cut short");
`endif

endmodule

FILE: sim/tb_gated_preamble_cross_correlator.sv
// Self-checking testbench for the gated preamble cross-correlator.
`timescale 1ns / 1ps

class peak_scoreboard;
  logic signed [15:0] ring_re [64];
  logic signed [15:0] ring_im [64];
  logic signed [15:0] known_re [64];
  logic signed [15:0] known_im [64];
  logic [5:0]  wr_ptr;
  bit          open_search;
  logic [12:0] count;
  logic [15:0] thr_sq;
  logic [11:0] win_last;
  bit          predicted_peaks [$];
  int          errors;
  int          peaks_seen;
  int          results_seen;

  function new();
    for (int i = 0; i < 64; i++) begin
      ring_re[i] = 0; ring_im[i] = 0; known_re[i] = 0; known_im[i] = 0;
    end
    wr_ptr = 0; open_search = 0; count = 0;
    thr_sq = gpcc_pkg::THR_RST; win_last = gpcc_pkg::WIN_RST;
    errors = 0; peaks_seen = 0; results_seen = 0;
  endfunction

  function void set_reg(logic idx, logic [15:0] val);
    if (idx == gpcc_pkg::CFG_THR) thr_sq = val;
    else win_last = val[11:0];
  endfunction

  // Exact |C|^2 * 2^16 > thr * Ek * Ew over the window, oldest sample first.
  function bit passes_threshold();
    longint cre, cim, kr, ki, sr, si;
    logic [127:0] ek, ew, a, b, lhs, rhs;
    int j;
    cre = 0; cim = 0; ek = 0; ew = 0;
    for (int i = 0; i < 64; i++) begin
      j = (wr_ptr + i) % 64;
      kr = known_re[i]; ki = known_im[i];
      sr = ring_re[j]; si = ring_im[j];
      cre += kr * sr + ki * si;
      cim += kr * si - ki * sr;
      ek += 128'(kr * kr + ki * ki);
      ew += 128'(sr * sr + si * si);
    end
    a = 128'(cre < 0 ? -cre : cre);
    b = 128'(cim < 0 ? -cim : cim);
    lhs = (a * a + b * b) << 16;
    rhs = 128'(thr_sq) * ek * ew;
    return lhs > rhs;
  endfunction

  function void note_beat(logic mode, logic trig, logic [15:0] re, logic [15:0] im,
                          logic [5:0] idx);
    bit peak;
    peak = 0;
    if (mode == gpcc_pkg::MODE_LOAD) begin
      known_re[idx] = re; known_im[idx] = im;
    end else begin
      ring_re[wr_ptr] = re; ring_im[wr_ptr] = im;
      wr_ptr = wr_ptr + 1;
      if (trig) begin
        open_search = 1; count = 0;
      end
      if (open_search) begin
        if (passes_threshold()) begin
          peak = 1; open_search = 0;
        end
        if (count == {1'b0, win_last}) open_search = 0;
      end
      if (count != gpcc_pkg::COUNT_MAX) count++;
    end
    predicted_peaks.push_back(peak);
  endfunction

  function void check_beat(logic actual);
    bit want;
    results_seen++;
    if (actual === 1'b1) peaks_seen++;
    if (predicted_peaks.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual cross_peak=%b", $time, actual);
      errors++;
      return;
    end
    want = predicted_peaks.pop_front();
    if (actual !== want) begin
      $display("%0t: cross_peak mismatch, expected %b, actual %b", $time, want, actual);
      errors++;
    end
  endfunction
endclass

module tb_gated_preamble_cross_correlator;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic in_mode = 0, in_auto_peak = 0;
  logic signed [gpcc_pkg::FIELD_W-1:0] in_sample_re = 0, in_sample_im = 0;
  logic [gpcc_pkg::IDX_W-1:0] in_coef_index = 0;
  logic out_valid, out_ready = 0, out_cross_peak;
  logic cfg_we = 0;
  logic [gpcc_pkg::CFG_IDX_W-1:0] cfg_index = 0;
  logic [gpcc_pkg::CFG_W-1:0] cfg_wdata = 0;

  peak_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int items_sent = 0;
  logic signed [15:0] pre_re [64];
  logic signed [15:0] pre_im [64];

  gated_preamble_cross_correlator DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_beat(in_mode, in_auto_peak, in_sample_re, in_sample_im, in_coef_index);
    if (rst_n && out_valid && out_ready) sb.check_beat(out_cross_peak);
  end

  // Receiver: random back-pressure plus a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(logic mode, logic trig, logic [15:0] re, logic [15:0] im,
                           logic [5:0] idx);
    in_valid <= 1'b1;
    in_mode <= mode; in_auto_peak <= trig;
    in_sample_re <= re; in_sample_im <= im; in_coef_index <= idx;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [gpcc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (sb.predicted_peaks.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_preamble();
    for (int i = 0; i < 64; i++) begin
      pre_re[i] = rand_field(); pre_im[i] = rand_field();
      send_beat(gpcc_pkg::MODE_LOAD, $urandom_range(1), pre_re[i], pre_im[i], 6'(i));
    end
  endtask

  // Replay the preamble (sometimes disturbed) and trigger near its end.
  task automatic send_preamble_copy();
    int trig_at;
    int noisy;
    logic [15:0] re, im;
    trig_at = $urandom_range(50, 63);
    noisy = ($urandom_range(3) == 0);
    for (int i = 0; i < 64; i++) begin
      re = pre_re[i]; im = pre_im[i];
      if (noisy) begin
        re = re ^ 16'($urandom_range(4095)); im = im ^ 16'($urandom_range(4095));
      end
      send_beat(gpcc_pkg::MODE_SAMPLE, (i == trig_at) || ($urandom_range(99) == 0), re, im,
                6'($urandom));
    end
  endtask

  task automatic run_phase(int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    load_preamble();
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: send_preamble_copy();
        6: send_beat(gpcc_pkg::MODE_LOAD, $urandom_range(1), rand_field(), rand_field(),
                     6'($urandom));
        default:
          repeat ($urandom_range(1, 12))
            send_beat(gpcc_pkg::MODE_SAMPLE, $urandom_range(5) == 0, rand_field(),
                      rand_field(), 6'($urandom));
      endcase
    end
  endtask

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, loads with trigger set, trigger inside a search.
    send_beat(gpcc_pkg::MODE_LOAD, 1'b1, 16'h7FFF, 16'h8000, 6'd0);
    send_beat(gpcc_pkg::MODE_LOAD, 1'b0, 16'h8000, 16'h7FFF, 6'd63);
    send_beat(gpcc_pkg::MODE_LOAD, 1'b0, 16'h0000, 16'hFFFF, 6'd31);
    send_beat(gpcc_pkg::MODE_SAMPLE, 1'b1, 16'h0000, 16'h0000, 6'd0);
    send_beat(gpcc_pkg::MODE_SAMPLE, 1'b0, 16'h7FFF, 16'h7FFF, 6'd63);
    send_beat(gpcc_pkg::MODE_SAMPLE, 1'b0, 16'h8000, 16'h8000, 6'd5);
    send_beat(gpcc_pkg::MODE_SAMPLE, 1'b1, 16'h8000, 16'h7FFF, 6'd0);
    send_beat(gpcc_pkg::MODE_SAMPLE, 1'b0, 16'hFFFF, 16'h0001, 6'd0);
    for (int i = 0; i < 8; i++)
      send_beat(gpcc_pkg::MODE_SAMPLE, i == 4, 16'h7FFF, 16'h8000, 6'd0);
    for (int i = 0; i < 8; i++)
      send_beat(gpcc_pkg::MODE_SAMPLE, 1'b0, 16'h0000, 16'h0000, 6'd0);

    send_idle_pct = 17; recv_idle_pct = 68;
    write_reg(gpcc_pkg::CFG_THR, 16'd0); write_reg(gpcc_pkg::CFG_WIN, 16'd0);
    run_phase(330);

    write_reg(gpcc_pkg::CFG_THR, 16'd65535); write_reg(gpcc_pkg::CFG_WIN, 16'd4095);
    hold_request = 600;
    run_phase(330);

    send_idle_pct = 68; recv_idle_pct = 17;
    write_reg(gpcc_pkg::CFG_THR, 16'd32113); write_reg(gpcc_pkg::CFG_WIN, 16'd16);
    run_phase(330);

    write_reg(gpcc_pkg::CFG_THR, 16'($urandom));
    write_reg(gpcc_pkg::CFG_WIN, 16'($urandom_range(1, 40)));
    run_phase(330);

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(gpcc_pkg::CFG_THR, 16'($urandom_range(40000, 65535)));
    write_reg(gpcc_pkg::CFG_WIN, 16'($urandom_range(0, 8)));
    run_phase(330);

    in_valid <= 1'b0;
    while (sb.predicted_peaks.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d beats over five register settings, extremes included;", items_sent);
    $display("checked %0d results, %0d of them peaks.", sb.results_seen, sb.peaks_seen);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
